>>> design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/lhd_pkg.sv
package lhd_pkg;

  // field widths
  localparam int LIGHT_W     = 12;
  localparam int LEVEL_OUT_W = 12;
  localparam int CFG_W       = 12;
  localparam int WEIGHT_W    = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int EVENT_W     = 2;

  // parameter defaults and limits
  localparam int SAMPLES_PER_BLOCK_DEF = 10;
  localparam int SAMPLE_BITS_DEF       = 12;
  localparam int SAMPLE_BITS_MAX       = 16;
  localparam int CMP_W                 = SAMPLE_BITS_MAX + 1;

  // register reset values
  localparam logic [CFG_W-1:0]    THRESHOLD_RST = 12'd2048;
  localparam logic [CFG_W-1:0]    MARGIN_RST    = 12'd200;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 7'd60;
  localparam logic [WEIGHT_W-1:0] PERCENT_FULL  = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DARK_THRESHOLD    = 2'd0,
    REG_HYSTERESIS_MARGIN = 2'd1,
    REG_SMOOTHING_WEIGHT  = 2'd2
  } cfg_reg_e;

  typedef enum logic [EVENT_W-1:0] {
    EVENT_NONE = 2'd0,
    EVENT_LIT  = 2'd1,
    EVENT_DARK = 2'd2
  } light_event_e;

  // status from the block mean front end
  typedef struct packed {
    logic head_busy;
    logic mean_valid;
  } bm_status_t;

endpackage

>>> design/light_level_hysteresis_detector_top.sv
// path: sample, block sum, mean product, weighted sum, divide product and output registers
// throughput: one sample per cycle unless the output stalls; with one sample per block, a
//   sample waits while the last is held, for the feedback via the weight and /100 multipliers
// reset: asynchronous active low; clears counters, sum and valids, average to full scale,
//   lit room, registers to threshold 2048, margin 200, weight 60
`include "assert_macros.svh"

module light_level_hysteresis_detector_top import lhd_pkg::*; #(
  parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // sample channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [LIGHT_W-1:0]     light_sample_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [LEVEL_OUT_W-1:0] smoothed_level_o,
  output logic                   dark_flag_o,
  output logic [EVENT_W-1:0]     light_event_o
);

  localparam int  LVL_W     = SAMPLE_BITS;
  localparam int  NUM_W     = LVL_W + WEIGHT_W;
  // reciprocal of 100: ceil(2^K100 / 100), exact for numerators below 2^NUM_W
  localparam int  K100      = NUM_W + 7;
  localparam int  M100_W    = K100 - 5;
  localparam logic [M100_W-1:0] Mul100 = M100_W'(((64'd1 << K100) + 64'd99) / 64'd100);
  localparam int  P_W       = NUM_W + M100_W;
  localparam bit  OneSample = (SAMPLES_PER_BLOCK == 1);

  // configuration registers
  logic [CFG_W-1:0]    thr_q;
  logic [CFG_W-1:0]    margin_q;
  logic [WEIGHT_W-1:0] weight_q;

  // pipeline control
  logic       en;
  logic       in_acc;
  bm_status_t bm_status;
  logic [LVL_W-1:0] mean;

  // weight stage and divide stage
  logic                v3_q;
  logic [NUM_W-1:0]    num_q;
  logic [NUM_W-1:0]    num_d;
  logic                v4_q;
  logic [P_W-1:0]      p100_q;
  logic [WEIGHT_W-1:0] w_eff;
  logic [WEIGHT_W-1:0] w_rest;

  // average state and classification
  logic [LVL_W-1:0] avg_q;
  logic [LVL_W-1:0] avg_new;
  logic [LVL_W-1:0] avg_cur;
  logic             dark_q;
  logic             dark_d;
  logic [CFG_W:0]   upper;
  logic [CFG_W:0]   lower_s;
  logic [CMP_W-1:0] avg_cmp;
  logic             go_lit;
  logic             go_dark;
  light_event_e     event_d;

  // output register
  logic                   out_valid_q;
  logic [SAMPLE_BITS_MAX-1:0] avg_ext;
  logic [LEVEL_OUT_W-1:0] level_q;
  logic                   dark_flag_q;
  light_event_e           light_event_q;

  // the whole pipeline freezes only when a result is ready and the output is still held
  assign en         = !(v4_q && out_valid_q && out_stall_i);
  // with one sample per block, space block ends so the average feedback closes in time
  assign in_stall_o = !en || (OneSample && bm_status.head_busy);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THRESHOLD_RST;
      margin_q <= MARGIN_RST;
      weight_q <= WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DARK_THRESHOLD:    thr_q    <= cfg_wdata_i;
        REG_HYSTERESIS_MARGIN: margin_q <= cfg_wdata_i;
        REG_SMOOTHING_WEIGHT:  weight_q <= cfg_wdata_i[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // sample register, block accumulator, block mean
  lhd_block_mean #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_block_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .acc_i   (in_acc),
    .sample_i(light_sample_i),
    .status_o(bm_status),
    .mean_o  (mean)
  );

  // weights above 100 act as 100, so the average holds
  assign w_eff  = (weight_q > PERCENT_FULL) ? PERCENT_FULL : weight_q;
  assign w_rest = PERCENT_FULL - w_eff;

  // forward the average of the block still in the divide stage
  assign avg_new = p100_q[K100 +: LVL_W];
  assign avg_cur = v4_q ? avg_new : avg_q;

  // old times weight plus mean times the rest, at most 100 times full scale
  assign num_d = NUM_W'(avg_cur) * NUM_W'(w_eff) + NUM_W'(mean) * NUM_W'(w_rest);

  // hysteresis bounds: the lower bound may go negative and then never signals dark
  assign upper   = {1'b0, thr_q} + {1'b0, margin_q};
  assign lower_s = {1'b0, thr_q} - {1'b0, margin_q};
  assign avg_cmp = CMP_W'(avg_new);
  assign go_lit  = dark_q && (avg_cmp > CMP_W'(upper));
  assign go_dark = !dark_q && !lower_s[CFG_W] && (avg_cmp < CMP_W'(lower_s[CFG_W-1:0]));

  always_comb begin
    dark_d  = dark_q;
    event_d = EVENT_NONE;
    if (go_lit) begin
      dark_d  = 1'b0;
      event_d = EVENT_LIT;
    end else if (go_dark) begin
      dark_d  = 1'b1;
      event_d = EVENT_DARK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      avg_q       <= '1;
      dark_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        v3_q <= bm_status.mean_valid;
        v4_q <= v3_q;
        if (v4_q) begin
          avg_q  <= avg_new;
          dark_q <= dark_d;
        end
      end
      if (en && v4_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign avg_ext = SAMPLE_BITS_MAX'(avg_new);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q  <= num_d;
      p100_q <= P_W'(num_q) * P_W'(Mul100);
    end
    if (en && v4_q) begin
      level_q       <= avg_ext[LEVEL_OUT_W-1:0];
      dark_flag_q   <= dark_d;
      light_event_q <= event_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign smoothed_level_o = level_q;
  assign dark_flag_o      = dark_flag_q;
  assign light_event_o    = light_event_q;

  // two block means never reach the weight stage in adjacent cycles
  `ASSERT_ALWAYS(a_no_adjacent_update, clk_i, rst_ni, !(bm_status.mean_valid && v3_q), "block means too close for average feedback")
  // a reported transition agrees with the reported flag
  `ASSERT_IMPLY(a_event_matches_flag, clk_i, rst_ni, out_valid_q, ((light_event_q == EVENT_DARK) && !dark_flag_q) == 1'b0 && ((light_event_q == EVENT_LIT) && dark_flag_q) == 1'b0, "event disagrees with dark flag")
  // the dark flag changes only when a result is produced
  `ASSERT_IMPLY(a_dark_moves_with_result, clk_i, rst_ni, dark_q != $past(dark_q), $past(en && v4_q), "dark flag changed without a result")

endmodule

>>> design/lhd_block_mean.sv
module lhd_block_mean import lhd_pkg::*; #(
  parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   acc_i,
  input  logic [LIGHT_W-1:0]     sample_i,
  output bm_status_t             status_o,
  output logic [SAMPLE_BITS-1:0] mean_o
);

  localparam int CLOG_N = $clog2(SAMPLES_PER_BLOCK);
  localparam int CNT_W  = (SAMPLES_PER_BLOCK > 1) ? CLOG_N : 1;
  localparam int SUM_W  = SAMPLE_BITS + CLOG_N;
  localparam int KM     = SUM_W + CLOG_N;
  localparam int MM_W   = KM + 1;
  localparam int PM_W   = SUM_W + MM_W;
  // ceil(2^KM / n), exact floor division for any sum below 2^SUM_W
  localparam logic [MM_W-1:0] MeanMul =
    MM_W'(((64'd1 << KM) + 64'(SAMPLES_PER_BLOCK) - 64'd1) / 64'(SAMPLES_PER_BLOCK));
  localparam logic [CNT_W-1:0] LastCnt = CNT_W'(SAMPLES_PER_BLOCK - 1);

  logic [SAMPLE_BITS_MAX-1:0] samp_ext;
  logic [SAMPLE_BITS-1:0]     samp_q;
  logic                       v0_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [SUM_W-1:0]           sum_q;
  logic [SUM_W-1:0]           sum_add;
  logic                       last;
  logic [SUM_W-1:0]           bsum_q;
  logic                       v1_q;
  logic [PM_W-1:0]            prod_q;
  logic                       v2_q;

  // zero-extend to the largest sample width; the sample register keeps the sample width
  assign samp_ext = SAMPLE_BITS_MAX'(sample_i);
  assign sum_add  = sum_q + SUM_W'(samp_q);
  assign last     = (cnt_q == LastCnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      cnt_q <= '0;
      sum_q <= '0;
    end else if (en_i) begin
      v0_q <= acc_i;
      v2_q <= v1_q;
      v1_q <= v0_q && last;
      if (v0_q) begin
        if (last) begin
          cnt_q <= '0;
          sum_q <= '0;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
          sum_q <= sum_add;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      samp_q <= samp_ext[SAMPLE_BITS-1:0];
    end
    if (en_i) begin
      if (v0_q && last) begin
        bsum_q <= sum_add;
      end
      prod_q <= PM_W'(bsum_q) * PM_W'(MeanMul);
    end
  end

  assign mean_o              = prod_q[KM +: SAMPLE_BITS];
  assign status_o.head_busy  = v0_q;
  assign status_o.mean_valid = v2_q;

endmodule
